FILE: sv/ddo_pkg.sv
// Shared types, constants and CORDIC angle table for the odometry block.
package ddo_pkg;

  // Transaction handed from the front part to the back part.
  typedef struct packed {
    logic signed [32:0] dl;
    logic signed [32:0] dr;
    logic [15:0]        per;
  } ddo_job_t;

  // Result transaction.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hd;
    logic signed [31:0] spd;
  } ddo_res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WL, ST_WR, ST_CEN, ST_CORDIC, ST_PX, ST_PY, ST_TURN,
    ST_DIV, ST_DONE
  } ddo_state_t;

  localparam logic [1:0] REG_DIST = 2'd0;
  localparam logic [1:0] REG_GAIN = 2'd1;

  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
  localparam int MAX_STEPS = 24;

  // Arctangent of 2^-i in 2^-32 turn units.
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

FILE: sv/differential_drive_odometry.sv
// Top level of the differential-drive wheel odometry block.
//  channel | ports                                      | handshake
//  input   | in_left_count in_right_count in_sample_period | push / full
//  result  | out_x_position out_y_position out_heading out_speed | empty / pop
//  config  | cfg_we cfg_index cfg_data                  | write on cfg_we
// An item occupies the back part through the CORDIC loop and the bit-serial
// 64-bit speed divider, and the back part takes the next item only after the
// result of the last one is stored in its result registers.
// Reset is synchronous, active low; pose, heading and last counts clear.
// The front queue holds two transactions, so input stalls only when it
// fills behind a busy back part or an untaken result.
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] in_left_count,
  input  logic signed [31:0] in_right_count,
  input  logic [15:0]        in_sample_period,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_x_position,
  output logic signed [31:0] out_y_position,
  output logic [15:0]        out_heading,
  output logic signed [31:0] out_speed,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  logic [23:0] dist_r, gain_r;
  logic jv, jt, rv;
  ddo_pkg::ddo_job_t job;
  ddo_pkg::ddo_res_t res;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= 24'd65536;
      gain_r <= 24'd65536;
    end else if (cfg_we) begin
      if (cfg_index == ddo_pkg::REG_DIST) dist_r <= cfg_data;
      if (cfg_index == ddo_pkg::REG_GAIN) gain_r <= cfg_data;
    end
  end

  ddo_front u_front (
    .clk, .rst_n, .push, .full, .in_left_count, .in_right_count,
    .in_sample_period, .job_valid(jv), .job_take(jt), .job(job)
  );

  ddo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .job_valid(jv), .job_take(jt), .job(job),
    .dist_tick(dist_r), .gain(gain_r), .res_valid(rv), .res_take(pop),
    .res(res)
  );

  assign empty = !rv;
  assign out_x_position = res.x;
  assign out_y_position = res.y;
  assign out_heading = res.hd;
  assign out_speed = res.spd;
endmodule

FILE: sv/ddo_front.sv
// Front part: takes count transactions and forms wrapped tick deltas.
module ddo_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  in_left_count,
  input  logic signed [31:0]  in_right_count,
  input  logic [15:0]         in_sample_period,
  output logic                job_valid,
  input  logic                job_take,
  output ddo_pkg::ddo_job_t   job
);
  logic [31:0] last_l_r, last_r_r;
  // Two-entry queue toward the back part.
  ddo_pkg::ddo_job_t q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       acc;
  ddo_pkg::ddo_job_t nj;

  assign full = cnt_r == 2'd2;
  assign acc  = push && !full;
  assign job_valid = cnt_r != 2'd0;
  assign job = q_r[rd_r];

  // Classify: wrapped signed deltas, period forced nonzero.
  always_comb begin
    nj.dr  = 33'(signed'(32'(in_right_count - last_r_r)));
    nj.dl  = 33'(signed'(32'(in_left_count - last_l_r)));
    nj.per = (in_sample_period == 16'd0) ? 16'd1 : in_sample_period;
  end

  // Hold last counts and advance queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_l_r <= '0;
      last_r_r <= '0;
      cnt_r    <= '0;
      rd_r     <= 1'b0;
      wr_r     <= 1'b0;
    end else begin
      if (acc) begin
        last_l_r <= in_left_count;
        last_r_r <= in_right_count;
        q_r[wr_r] <= nj;
        wr_r <= ~wr_r;
      end
      if (job_valid && job_take) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(acc) - 2'(job_valid && job_take);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (last_l_r == $past(in_left_count)))
    else $error("left count not held");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !(job_valid))
    else $error("job shown from empty queue");
endmodule

FILE: sv/ddo_back.sv
// Back part: scaling, CORDIC, pose update, heading and speed division.
module ddo_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_take,
  input  ddo_pkg::ddo_job_t job,
  input  logic [23:0]       dist_tick,
  input  logic [23:0]       gain,
  output logic              res_valid,
  input  logic              res_take,
  output ddo_pkg::ddo_res_t res
);
  localparam int NSTEP = (CORDIC_STEPS < ddo_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                             : ddo_pkg::MAX_STEPS;

  ddo_pkg::ddo_state_t st_r, st_nxt;
  ddo_pkg::ddo_job_t   j_r;
  logic signed [63:0]  wl_r, wr_r, cen_r;
  logic signed [31:0]  dc_r, px_r, py_r, spd_r;
  logic [15:0]         ang_r;
  // Result registers, so the next transaction can run while one waits.
  logic signed [31:0]  ox_r, oy_r;
  logic [15:0]         oh_r;
  logic signed [33:0]  cx_r, cy_r, cz_r;
  logic [4:0]          it_r;
  logic                flip_r;
  // Divider: magnitude restoring division, one quotient bit a cycle.
  logic [63:0]         dq_r;
  logic [16:0]         drem_r;
  logic                dneg_r;
  logic [5:0]          dcnt_r;
  logic signed [63:0]  diff;
  logic                out_v_r;

  // Shared multiplier operands.
  logic signed [63:0] prod;
  logic signed [33:0] ma;
  logic signed [32:0] mb33;
  logic signed [63:0] big;
  logic signed [33:0] sx, sy, step_x, step_y;
  logic [15:0]        fa;
  logic signed [33:0] z0;
  logic [16:0]        trial;
  logic [63:0]        dmag;
  logic signed [65:0] sum;
  logic [47:0]        turn;
  logic signed [63:0] q64;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign job_take  = st_r == ddo_pkg::ST_IDLE && job_valid;
  assign res_valid = out_v_r;
  assign res.x = ox_r;
  assign res.y = oy_r;
  assign res.hd = oh_r;
  assign res.spd = spd_r;

  // Operands for the single 34x33 multiply per state.
  always_comb begin
    mb33 = j_r.dl;
    ma = 34'(signed'({1'b0, dist_tick}));
    case (st_r)
      ddo_pkg::ST_WR: mb33 = j_r.dr;
      ddo_pkg::ST_PX: begin ma = cx_r; mb33 = 33'(dc_r); end
      ddo_pkg::ST_PY: begin ma = cy_r; mb33 = 33'(dc_r); end
      default: ;
    endcase
    prod = 64'(ma) * 64'(mb33);
    sum = 66'(wl_r) + 66'(wr_r);
    big = 64'(sum / 2);
    fa = ang_r;
    if (ang_r >= 16'h4000 && ang_r < 16'hC000) fa = ang_r ^ 16'h8000;
    z0 = 34'(signed'(fa)) <<< 16;
    sx = cx_r >>> it_r;
    sy = cy_r >>> it_r;
    step_x = cz_r[33] ? cx_r + sy : cx_r - sy;
    step_y = cz_r[33] ? cy_r - sx : cy_r + sx;
    diff = wr_r - wl_r;
    // Only bits 47:32 of the rounded turn are kept.
    turn = diff[47:0] * 48'(gain) + 48'h80000000;
    dmag = cen_r[63] ? 64'(-cen_r) : 64'(cen_r);
    trial = {drem_r[15:0], dq_r[63]};
    q64 = dneg_r ? -$signed(dq_r) : $signed(dq_r);
  end

  // Sequence one transaction through its steps.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ddo_pkg::ST_IDLE:   if (job_valid) st_nxt = ddo_pkg::ST_WL;
      ddo_pkg::ST_WL:     st_nxt = ddo_pkg::ST_WR;
      ddo_pkg::ST_WR:     st_nxt = ddo_pkg::ST_CEN;
      ddo_pkg::ST_CEN:    st_nxt = ddo_pkg::ST_CORDIC;
      ddo_pkg::ST_CORDIC: if (it_r == 5'(NSTEP - 1)) st_nxt = ddo_pkg::ST_PX;
      ddo_pkg::ST_PX:     st_nxt = ddo_pkg::ST_PY;
      ddo_pkg::ST_PY:     st_nxt = ddo_pkg::ST_TURN;
      ddo_pkg::ST_TURN:   st_nxt = ddo_pkg::ST_DIV;
      ddo_pkg::ST_DIV:    if (dcnt_r == 6'd63) st_nxt = ddo_pkg::ST_DONE;
      ddo_pkg::ST_DONE:   if (!out_v_r) st_nxt = ddo_pkg::ST_IDLE;
      default:            st_nxt = ddo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ddo_pkg::ST_IDLE;
      px_r <= '0;
      py_r <= '0;
      ang_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (res_take && out_v_r) out_v_r <= 1'b0;
      case (st_r)
        ddo_pkg::ST_IDLE: if (job_valid) j_r <= job;
        ddo_pkg::ST_WL: wl_r <= prod;
        ddo_pkg::ST_WR: wr_r <= prod;
        ddo_pkg::ST_CEN: begin
          cen_r  <= big;
          dc_r   <= sat32(66'(big));
          cx_r   <= ddo_pkg::CORDIC_K;
          cy_r   <= '0;
          cz_r   <= z0;
          flip_r <= fa != ang_r;
          it_r   <= '0;
        end
        ddo_pkg::ST_CORDIC: begin
          // Negate both results on the last step when the heading was flipped.
          cx_r <= (it_r == 5'(NSTEP - 1) && flip_r) ? -step_x : step_x;
          cy_r <= (it_r == 5'(NSTEP - 1) && flip_r) ? -step_y : step_y;
          cz_r <= cz_r[33] ? cz_r + ddo_pkg::atan_turn(it_r)
                           : cz_r - ddo_pkg::atan_turn(it_r);
          it_r <= it_r + 5'd1;
        end
        ddo_pkg::ST_PX:
          px_r <= sat32(66'(px_r) + 66'((prod + 64'sh20000000) >>> 30));
        ddo_pkg::ST_PY:
          py_r <= sat32(66'(py_r) + 66'((prod + 64'sh20000000) >>> 30));
        ddo_pkg::ST_TURN: begin
          ang_r  <= ang_r + turn[47:32];
          dq_r   <= dmag;
          drem_r <= '0;
          dneg_r <= cen_r[63];
          dcnt_r <= '0;
        end
        ddo_pkg::ST_DIV: begin
          dcnt_r <= dcnt_r + 6'd1;
          if (trial >= {1'b0, j_r.per}) begin
            drem_r <= trial - {1'b0, j_r.per};
            dq_r   <= {dq_r[62:0], 1'b1};
          end else begin
            drem_r <= trial;
            dq_r   <= {dq_r[62:0], 1'b0};
          end
        end
        ddo_pkg::ST_DONE: if (!out_v_r) begin
          ox_r    <= px_r;
          oy_r    <= py_r;
          oh_r    <= ang_r;
          spd_r   <= sat32(66'(q64));
          out_v_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> st_r == ddo_pkg::ST_IDLE)
    else $error("job taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !res_take) |=> out_v_r && $stable(ox_r))
    else $error("result dropped before taken");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ddo_pkg::ST_CORDIC) |-> it_r < 5'(NSTEP))
    else $error("CORDIC step count overrun");
endmodule
